// ----- rtl/tbrw_pkg.sv -----
package tbrw_pkg;

    // Field widths of the command and result ports.
    localparam int SEQ_W  = 32;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 2;
    localparam int CNT_W  = 7;
    localparam int OFF_W  = 16;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEFAULT   = 4096;
    localparam int MAX_READ_DEFAULT = 64;

    // Command codes carried on the action port.
    localparam logic [ACT_W-1:0] ACT_ACCEPT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

endpackage

// ----- rtl/tcp_byte_reassembly_window_core.sv -----
// TCP reassembly window. Each slot of one WINDOW-deep RAM holds a payload byte
// and its present bit, addressed by sequence number modulo WINDOW. An accept
// request leaves busy low, so segment bytes can be issued on every clock while
// the block is idle. A read request keeps busy high until it issues its final
// strobe, which carries the last flag; results stream at one per
// cycle, limited by the single RAM read port. Each byte is held in a register
// until the next slot shows whether it is the last; an empty marker is sent
// when nothing is handed out. The results cannot be held off: the receiver
// must take each strobe as it comes. After reset and after every restart
// request the block sweeps the RAM to clear the present bits, one slot per
// cycle, which keeps busy high until every slot is cleared.
module tcp_byte_reassembly_window_core #(
    parameter int WINDOW   = tbrw_pkg::WINDOW_DEFAULT,
    parameter int MAX_READ = tbrw_pkg::MAX_READ_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tbrw_pkg::ACT_W-1:0]  action,
    input  logic [tbrw_pkg::SEQ_W-1:0]  seq,
    input  logic [tbrw_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_of_segment,
    input  logic [tbrw_pkg::CNT_W-1:0]  max_count,
    output logic                        strobe,
    output logic [tbrw_pkg::BYTE_W-1:0] out_byte,
    output logic                        has_byte,
    output logic                        last,
    output logic [tbrw_pkg::SEQ_W-1:0]  next_seq
);

    import tbrw_pkg::*;

    localparam int AW    = $clog2(WINDOW);
    localparam int RAM_W = BYTE_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SEQ_W-1:0]  ne_reg, ne_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic              pend_reg, pend_next;
    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;

    logic              strobe_reg, strobe_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              has_byte_reg, has_byte_next;
    logic              last_reg, last_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;

    logic [SEQ_W-1:0]  byte_seq;
    logic [SEQ_W-1:0]  seq_gap;
    logic [SEQ_W-1:0]  ne_inc;
    logic              take;

    tbrw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence of the incoming byte and its distance from the window base.
    assign byte_seq = seq + {{(SEQ_W-OFF_W){1'b0}}, off_reg};
    assign seq_gap  = byte_seq - ne_reg;
    assign ne_inc   = ne_reg + 1'b1;

    // In a read, the slot read last cycle is handed out while it is present
    // and the byte limit has not been reached.
    assign take = ram_rdata[BYTE_W] && (cnt_reg < limit_reg);

    // Command decode, read sequencing and clearing sweep.
    always_comb
    begin
        state_next     = state_reg;
        ne_next        = ne_reg;
        off_next       = off_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;

        strobe_next    = 1'b0;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        last_next      = last_reg;
        next_seq_next  = next_seq_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        ram_raddr = ne_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_ACCEPT:
                        begin
                            // Keep the byte only inside the receive window.
                            if (seq_gap[SEQ_W-1:AW] == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = byte_seq[AW-1:0];
                                ram_wdata = {1'b1, data_byte};
                            end
                            off_next = last_of_segment ? '0 : off_reg + 1'b1;
                        end
                        ACT_READ:
                        begin
                            // The first slot is read from the RAM this cycle.
                            limit_next = (max_count > CNT_W'(MAX_READ)) ?
                                         CNT_W'(MAX_READ) : max_count;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_READ;
                        end
                        ACT_RESTART:
                        begin
                            ne_next    = seq;
                            off_next   = '0;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(WINDOW - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (take)
                begin
                    // Clear the slot, advance and prefetch the next slot. The
                    // byte is held until the next slot shows whether it is the last.
                    ram_we         = 1'b1;
                    ram_waddr      = ne_reg[AW-1:0];
                    ram_wdata      = '0;
                    ram_raddr      = ne_inc[AW-1:0];
                    ne_next        = ne_inc;
                    cnt_next       = cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_byte_next = ram_rdata[BYTE_W-1:0];
                    if (pend_reg)
                    begin
                        strobe_next   = 1'b1;
                        out_byte_next = pend_byte_reg;
                        has_byte_next = 1'b1;
                        last_next     = 1'b0;
                        next_seq_next = ne_reg;
                    end
                end
                else
                begin
                    // End of the read: flush the held byte, or send the empty
                    // marker when nothing was handed out.
                    strobe_next   = 1'b1;
                    out_byte_next = pend_reg ? pend_byte_reg : '0;
                    has_byte_next = pend_reg;
                    last_next     = 1'b1;
                    next_seq_next = ne_reg;
                    pend_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; a clearing sweep starts right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ne_reg     <= '0;
            off_reg    <= '0;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            limit_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ne_reg     <= ne_next;
            off_reg    <= off_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            limit_reg  <= limit_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers of the held byte and the result port.
    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        has_byte_reg  <= has_byte_next;
        last_reg      <= last_next;
        next_seq_reg  <= next_seq_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_byte = out_byte_reg;
    assign has_byte = has_byte_reg;
    assign last     = last_reg;
    assign next_seq = next_seq_reg;

endmodule

// ----- rtl/tbrw_ram.sv -----
module tbrw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
